/* sv/frtcu_pkg.sv */
// ---------------------------------------------------------------------------
// frtcu_pkg: shared types and constants of the fixed rate tick catch-up block
// Field widths, register indexes, the configuration bundle and the run and
// tick records passed between the front end, the run queue and the back end.
// ---------------------------------------------------------------------------
package frtcu_pkg;

    localparam int NOW_W           = 63;
    localparam int IVL_W           = 47;
    localparam int LIM_W           = 7;
    localparam int IDX_W           = 64;
    localparam int CATCH_UP_MAX    = 64;
    localparam int CM1_W           = $clog2(CATCH_UP_MAX);
    localparam int CNT_W           = $clog2(CATCH_UP_MAX + 1);
    localparam int PROD_W          = IVL_W + CM1_W;
    localparam int DIV_CNT_W       = $clog2(NOW_W);
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = NOW_W;

    localparam int IN_DATA_W       = ((NOW_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W    = 7 * NOW_W;
    localparam int OUT_DATA_W      = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] REG_TICK_INTERVAL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EPOCH_TIME     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LAG_MODE       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CATCH_UP_LIMIT = 2'd3;

    localparam logic [IVL_W-1:0] TICK_INTERVAL_RST = IVL_W'(1000000);
    localparam logic [LIM_W-1:0] CATCH_UP_LIMIT_RST = LIM_W'(1);

    typedef struct packed {
        logic [IVL_W-1:0] ivl;       // never zero
        logic [NOW_W-1:0] epoch;
        logic             lag_mode;
        logic [LIM_W-1:0] limit;
    } cfg_t;

    // one wake-up's worth of ticks to emit
    typedef struct packed {
        logic [IDX_W-1:0] start_idx;
        logic [CM1_W-1:0] cnt_m1;
        logic [NOW_W-1:0] logical;
        logic [NOW_W-1:0] late;
        logic [NOW_W-1:0] skipped;
        logic [NOW_W-1:0] tot_skipped;
    } run_t;

    typedef struct packed {
        logic [NOW_W-1:0] tick_number;
        logic [NOW_W-1:0] logical_time;
        logic [NOW_W-1:0] lateness;
        logic [NOW_W-1:0] skipped_before;
        logic             last_in_run;
        logic [NOW_W-1:0] total_executed;
        logic [NOW_W-1:0] total_skipped;
        logic [NOW_W-1:0] worst_lateness;
    } tick_t;

endpackage

/* sv/fixed_rate_tick_catch_up.sv */
// ---------------------------------------------------------------------------
// fixed_rate_tick_catch_up: fixed rate tick scheduler with catch-up
// Configuration registers, front end, run queue and tick emitter.
// ---------------------------------------------------------------------------
// Each wake-up transaction carries the current time; the block emits the due
// ticks of the grid epoch_time + n * tick_interval, oldest first, at most one
// per wake-up in skip mode and up to catch_up_limit (capped at 64) in catch-up
// mode, counting older ones as skipped. The front end works each wake-up through
// its bit-serial 63-step divider and takes the next wake-up once its run
// record is in the queue; the emitter then sends one tick per cycle while the
// output is taken. Write the registers only while idle.
module fixed_rate_tick_catch_up #(
    parameter int QUEUE_DEPTH = frtcu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [frtcu_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [frtcu_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [frtcu_pkg::IN_DATA_W-1:0]     s_tdata,   // now_time
    input  logic [0:0]                          s_tuser,   // cancel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // tick_number, logical_time, lateness, skipped_before, total_executed,
    // total_skipped, worst_lateness
    output logic [frtcu_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                                m_tlast    // last_in_run
);
    import frtcu_pkg::*;

    logic [IVL_W-1:0] ivl_reg;
    logic [NOW_W-1:0] epoch_reg;
    logic             lag_mode_reg;
    logic [LIM_W-1:0] limit_reg;

    cfg_t  cfg;
    logic  push, q_full, pop, q_empty;
    run_t  push_run, q_data;
    tick_t tick;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ivl_reg      <= TICK_INTERVAL_RST;
            epoch_reg    <= '0;
            lag_mode_reg <= 1'b0;
            limit_reg    <= CATCH_UP_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TICK_INTERVAL:  ivl_reg      <= cfg_data[IVL_W-1:0];
                REG_EPOCH_TIME:     epoch_reg    <= cfg_data[NOW_W-1:0];
                REG_LAG_MODE:       lag_mode_reg <= cfg_data[0];
                REG_CATCH_UP_LIMIT: limit_reg    <= cfg_data[LIM_W-1:0];
            endcase
        end
    end

    // a zero interval behaves as one
    assign cfg.ivl      = (ivl_reg == '0) ? IVL_W'(1) : ivl_reg;
    assign cfg.epoch    = epoch_reg;
    assign cfg.lag_mode = lag_mode_reg;
    assign cfg.limit    = limit_reg;

    frtcu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .now_time (s_tdata[NOW_W-1:0]),
        .cancel   (s_tuser[0]),
        .push     (push),
        .push_run (push_run),
        .q_full   (q_full)
    );

    frtcu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (push_run),
        .full    (q_full),
        .rd_en   (pop),
        .rd_data (q_data),
        .empty   (q_empty)
    );

    frtcu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_empty   (q_empty),
        .q_data    (q_data),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_tick  (tick)
    );

    assign m_tdata = {(OUT_DATA_W - OUT_FIELDS_W)'(0),
                      tick.worst_lateness,
                      tick.total_skipped,
                      tick.total_executed,
                      tick.skipped_before,
                      tick.lateness,
                      tick.logical_time,
                      tick.tick_number};
    assign m_tlast = tick.last_in_run;

endmodule

/* sv/frtcu_front.sv */
// ---------------------------------------------------------------------------
// frtcu_front: wake-up intake and classification
// Divides the elapsed time by the interval one bit per cycle, works out how
// many grid points are due, how many are skipped and emitted, and pushes a run
// record into the run queue for each uncancelled wake-up with new ticks due.
// ---------------------------------------------------------------------------
module frtcu_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  frtcu_pkg::cfg_t               cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [frtcu_pkg::NOW_W-1:0]   now_time,
    input  logic                          cancel,
    output logic                          push,
    output frtcu_pkg::run_t               push_run,
    input  logic                          q_full
);
    import frtcu_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_CHK  = 3'd2;
    localparam logic [2:0] ST_CNT  = 3'd3;
    localparam logic [2:0] ST_UPD  = 3'd4;
    localparam logic [2:0] ST_PUSH = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic [NOW_W-1:0]     now_reg;
    logic                 cancel_reg;
    logic [NOW_W-1:0]     dq_reg;        // dividend in, quotient out
    logic [IVL_W:0]       rem_reg;
    logic [DIV_CNT_W-1:0] step_reg;
    logic [IDX_W-1:0]     due_reg;
    logic [IDX_W-1:0]     pm1_reg;       // pending minus one
    logic [CM1_W-1:0]     cm1_reg;
    logic [IDX_W-1:0]     skipped_reg;
    logic [IDX_W-1:0]     start_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [NOW_W-1:0]     base_reg;
    logic [IDX_W-1:0]     next_index_reg;
    logic [NOW_W-1:0]     skip_tot_reg;

    logic [IDX_W-1:0]     elapsed;
    logic [IVL_W:0]       trial;
    logic                 trial_ge;
    logic [IDX_W:0]       q_minus_idx;
    logic [CM1_W-1:0]     lim_m1;
    logic [CM1_W-1:0]     cm1;
    logic [IDX_W-1:0]     start_idx;
    logic [IDX_W-1:0]     skip_sum;

    assign in_ready = (state_reg == ST_IDLE);
    assign elapsed  = {1'b0, now_time} - {1'b0, cfg.epoch};

    assign trial    = {rem_reg[IVL_W-1:0], dq_reg[NOW_W-1]};
    assign trial_ge = (trial >= {1'b0, cfg.ivl});

    assign q_minus_idx = {2'b00, dq_reg} - {1'b0, next_index_reg};

    always_comb
    begin
        if (!cfg.lag_mode || cfg.limit == '0)
            lim_m1 = '0;
        else if (cfg.limit > LIM_W'(CATCH_UP_MAX))
            lim_m1 = CM1_W'(CATCH_UP_MAX - 1);
        else
            lim_m1 = CM1_W'(cfg.limit - 1'b1);
    end

    assign cm1 = (pm1_reg <= IDX_W'(lim_m1)) ? pm1_reg[CM1_W-1:0] : lim_m1;

    assign start_idx = next_index_reg + skipped_reg;
    assign skip_sum  = {1'b0, skip_tot_reg} + skipped_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !elapsed[IDX_W-1])
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (step_reg == DIV_CNT_W'(NOW_W - 1))
                    state_next = ST_CHK;
            end
            ST_CHK:
            begin
                // nothing due beyond what was already handled
                if (q_minus_idx[IDX_W])
                    state_next = ST_IDLE;
                else
                    state_next = ST_CNT;
            end
            ST_CNT:  state_next = ST_UPD;
            ST_UPD:  state_next = ST_PUSH;
            ST_PUSH:
            begin
                if (cancel_reg || !q_full)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            next_index_reg <= '0;
            skip_tot_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_UPD)
            begin
                next_index_reg <= cancel_reg ? start_idx : due_reg;
                skip_tot_reg   <= skip_sum[IDX_W-1] ? '1 : skip_sum[NOW_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                now_reg    <= now_time;
                cancel_reg <= cancel;
                dq_reg     <= elapsed[NOW_W-1:0];
                rem_reg    <= '0;
                step_reg   <= '0;
            end
            ST_DIV:
            begin
                rem_reg  <= trial_ge ? (trial - {1'b0, cfg.ivl}) : trial;
                dq_reg   <= {dq_reg[NOW_W-2:0], trial_ge};
                step_reg <= step_reg + 1'b1;
            end
            ST_CHK:
            begin
                due_reg <= {1'b0, dq_reg} + 1'b1;
                pm1_reg <= q_minus_idx[IDX_W-1:0];
            end
            ST_CNT:
            begin
                cm1_reg     <= cm1;
                skipped_reg <= pm1_reg - IDX_W'(cm1);
            end
            ST_UPD:
            begin
                start_reg <= start_idx;
                prod_reg  <= PROD_W'(cm1_reg) * PROD_W'(cfg.ivl);
                base_reg  <= now_reg - NOW_W'(rem_reg);
            end
            ST_PUSH:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign push                 = (state_reg == ST_PUSH) && !cancel_reg && !q_full;
    assign push_run.start_idx   = start_reg;
    assign push_run.cnt_m1      = cm1_reg;
    assign push_run.logical     = base_reg - NOW_W'(prod_reg);
    assign push_run.late        = NOW_W'(rem_reg) + NOW_W'(prod_reg);
    assign push_run.skipped     = skipped_reg[NOW_W-1:0];
    assign push_run.tot_skipped = skip_tot_reg;

endmodule

/* sv/frtcu_queue.sv */
// ---------------------------------------------------------------------------
// frtcu_queue: run queue between front end and back end
// A small register queue of run records so that the next wake-up can be
// classified while the previous run is still being emitted.
// ---------------------------------------------------------------------------
module frtcu_queue #(
    parameter int DEPTH = frtcu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  frtcu_pkg::run_t wr_data,
    output logic            full,
    input  logic            rd_en,
    output frtcu_pkg::run_t rd_data,
    output logic            empty
);
    import frtcu_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    run_t              slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [FILL_W-1:0] fill_reg;

    assign full    = (fill_reg == FILL_W'(DEPTH));
    assign empty   = (fill_reg == '0);
    assign rd_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (wr_en && !rd_en)
                fill_reg <= fill_reg + 1'b1;
            else if (rd_en && !wr_en)
                fill_reg <= fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

/* sv/frtcu_back.sv */
// ---------------------------------------------------------------------------
// frtcu_back: tick emitter
// Takes run records from the queue and, while the output is taken, emits
// their ticks one per cycle into an output register, stepping logical time
// and lateness by the interval, keeping the executed count and worst lateness.
// ---------------------------------------------------------------------------
module frtcu_back (
    input  logic            clk,
    input  logic            rst_n,
    input  frtcu_pkg::cfg_t cfg,
    input  logic            q_empty,
    input  frtcu_pkg::run_t q_data,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output frtcu_pkg::tick_t out_tick
);
    import frtcu_pkg::*;

    logic [IDX_W-1:0] idx_reg;
    logic [NOW_W-1:0] logical_reg;
    logic [NOW_W-1:0] late_reg;
    logic [NOW_W-1:0] skip_reg;
    logic [NOW_W-1:0] tot_skip_reg;
    logic [CNT_W-1:0] left_reg;
    logic             first_reg;
    logic [NOW_W-1:0] exec_reg;
    logic [NOW_W-1:0] max_late_reg;
    logic             out_valid_reg;
    tick_t            out_tick_reg;

    logic             emit;
    logic [NOW_W-1:0] exec_next;
    logic [NOW_W-1:0] max_late_next;

    assign pop  = (left_reg == '0) && !q_empty;
    assign emit = (left_reg != '0) && (!out_valid_reg || out_ready);

    assign exec_next     = (exec_reg == '1) ? exec_reg : exec_reg + 1'b1;
    assign max_late_next = (late_reg > max_late_reg) ? late_reg : max_late_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            exec_reg      <= '0;
            max_late_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
                left_reg <= CNT_W'(q_data.cnt_m1) + 1'b1;
            else if (emit)
                left_reg <= left_reg - 1'b1;

            if (emit)
            begin
                exec_reg      <= exec_next;
                max_late_reg  <= max_late_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            idx_reg      <= q_data.start_idx;
            logical_reg  <= q_data.logical;
            late_reg     <= q_data.late;
            skip_reg     <= q_data.skipped;
            tot_skip_reg <= q_data.tot_skipped;
            first_reg    <= 1'b1;
        end
        else if (emit)
        begin
            idx_reg     <= idx_reg + 1'b1;
            logical_reg <= logical_reg + NOW_W'(cfg.ivl);
            late_reg    <= late_reg - NOW_W'(cfg.ivl);
            first_reg   <= 1'b0;
        end

        if (emit)
        begin
            out_tick_reg.tick_number    <= idx_reg[NOW_W-1:0] + 1'b1;
            out_tick_reg.logical_time   <= logical_reg;
            out_tick_reg.lateness       <= late_reg;
            out_tick_reg.skipped_before <= first_reg ? skip_reg : '0;
            out_tick_reg.last_in_run    <= (left_reg == CNT_W'(1));
            out_tick_reg.total_executed <= exec_next;
            out_tick_reg.total_skipped  <= tot_skip_reg;
            out_tick_reg.worst_lateness <= max_late_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_tick  = out_tick_reg;

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb: testbench for fixed_rate_tick_catch_up
// Sends wake-up transactions under a range of register settings and checks
// every emitted tick against a predictor of the tick grid, the skip and
// catch-up rules and the running totals. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import frtcu_pkg::*;

    localparam logic [NOW_W-1:0] TIME_MAX = '1;
    localparam logic [IVL_W-1:0] IVL_MAX  = '1;
    localparam logic [IVL_W-1:0] IVL_DAY  = IVL_W'(64'd86400000000000);
    localparam int               SETTLE   = 150;
    localparam int               N_FIELDS = 7;

    // predicts the tick stream and holds the ticks still owed by the block
    class tick_scoreboard;
        logic [IVL_W-1:0] ivl        = TICK_INTERVAL_RST;
        logic [NOW_W-1:0] epoch      = '0;
        logic             catch_up   = 1'b0;
        logic [LIM_W-1:0] limit      = CATCH_UP_LIMIT_RST;
        logic [63:0]      grid_idx   = '0;
        logic [NOW_W-1:0] ticks_done = '0;
        logic [NOW_W-1:0] ticks_skip = '0;
        logic [NOW_W-1:0] worst_late = '0;
        tick_t            owed_ticks[$];
        int               errors     = 0;
        int               n_checked  = 0;
        int               n_wakeups  = 0;
        string            field_label[N_FIELDS] = '{"tick_number", "logical_time",
            "lateness", "skipped_before", "total_executed", "total_skipped",
            "worst_lateness"};

        function logic [63:0] interval();
            return (ivl == '0) ? 64'd1 : 64'(ivl);
        endfunction

        function logic [NOW_W-1:0] add_sat(logic [NOW_W-1:0] a, logic [63:0] b);
            logic [64:0] s;
            s = 65'(a) + 65'(b);
            return (s > 65'(TIME_MAX)) ? TIME_MAX : s[NOW_W-1:0];
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_TICK_INTERVAL:  ivl      = val[IVL_W-1:0];
                REG_EPOCH_TIME:     epoch    = val;
                REG_LAG_MODE:       catch_up = val[0];
                REG_CATCH_UP_LIMIT: limit    = val[LIM_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_wakeup(logic [NOW_W-1:0] now, logic cancel);
            logic [63:0]      step;
            logic [63:0]      due;
            logic [63:0]      cap;
            logic [63:0]      pending;
            logic [63:0]      count;
            logic [63:0]      skipped;
            logic [63:0]      logical;
            logic [63:0]      number;
            logic [NOW_W-1:0] late;
            tick_t            t;
            n_wakeups++;
            step = interval();
            if (now < epoch)
                return;
            due = (64'(now) - 64'(epoch)) / step + 64'd1;
            if (due <= grid_idx)
                return;
            if (!catch_up)
                cap = 64'd1;
            else if (limit == '0)
                cap = 64'd1;
            else if (limit > LIM_W'(CATCH_UP_MAX))
                cap = 64'(CATCH_UP_MAX);
            else
                cap = 64'(limit);
            pending    = due - grid_idx;
            count      = (pending < cap) ? pending : cap;
            skipped    = pending - count;
            grid_idx   = grid_idx + skipped;
            ticks_skip = add_sat(ticks_skip, skipped);
            if (cancel)
                return;
            for (int k = 0; k < int'(count); k++)
            begin
                logical    = 64'(epoch) + step * grid_idx;
                late       = now - logical[NOW_W-1:0];
                ticks_done = add_sat(ticks_done, 64'd1);
                if (late > worst_late)
                    worst_late = late;
                number           = grid_idx + 64'd1;
                t.tick_number    = number[NOW_W-1:0];
                t.logical_time   = logical[NOW_W-1:0];
                t.lateness       = late;
                t.skipped_before = (k == 0) ? skipped[NOW_W-1:0] : '0;
                t.last_in_run    = (64'(k) + 64'd1 == count);
                t.total_executed = ticks_done;
                t.total_skipped  = ticks_skip;
                t.worst_lateness = worst_late;
                owed_ticks.push_back(t);
                grid_idx++;
            end
        endfunction

        function void check_tick(logic [OUT_DATA_W-1:0] data, logic last);
            logic [NOW_W-1:0] got[N_FIELDS];
            logic [NOW_W-1:0] want[N_FIELDS];
            tick_t            t;
            n_checked++;
            if (owed_ticks.size() == 0)
            begin
                errors++;
                $display("%0t: tick transaction with none expected, tick_number %0d",
                         $time, data[NOW_W-1:0]);
                return;
            end
            t = owed_ticks.pop_front();
            want = '{t.tick_number, t.logical_time, t.lateness, t.skipped_before,
                     t.total_executed, t.total_skipped, t.worst_lateness};
            for (int i = 0; i < N_FIELDS; i++)
            begin
                got[i] = data[i*NOW_W +: NOW_W];
                if (got[i] !== want[i])
                begin
                    errors++;
                    $display("%0t: %s expected %0d, got %0d", $time,
                             field_label[i], want[i], got[i]);
                end
            end
            if (last !== t.last_in_run)
            begin
                errors++;
                $display("%0t: last_in_run expected %0b, got %0b", $time,
                         t.last_in_run, last);
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;    // now_time
    logic [0:0]            s_tuser;    // cancel
    logic                  m_tvalid;
    logic                  m_tready;
    // tick_number, logical_time, lateness, skipped_before, total_executed,
    // total_skipped, worst_lateness
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;    // last_in_run

    tick_scoreboard sb;
    logic           idle_on;
    int             n_settings;

    fixed_rate_tick_catch_up DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    // time of grid point idx plus an offset, under the current settings
    function automatic logic [NOW_W-1:0] grid_time(logic [63:0] idx, logic [63:0] off);
        logic [127:0] t;
        t = 128'(sb.epoch) + 128'(idx) * 128'(sb.interval()) + 128'(off);
        return (t > 128'(TIME_MAX)) ? TIME_MAX : t[NOW_W-1:0];
    endfunction

    // mostly wake-ups a few grid points ahead, some early, some that land on
    // nothing new, and some loosely bounded noise
    function automatic logic [NOW_W-1:0] pick_now();
        int          r;
        int          d;
        logic [63:0] tgt;
        logic [63:0] bound;
        r = $urandom_range(0, 99);
        if (r < 10)
            return (sb.epoch == '0) ? '0 : NOW_W'(rnd64() % 64'(sb.epoch));
        if (r < 25)
        begin
            bound = 64'(grid_time(sb.grid_idx + 64'd100, 64'd0)) + 64'd1;
            return NOW_W'(rnd64() % bound);
        end
        r = $urandom_range(0, 99);
        if (r < 60)
            d = $urandom_range(1, 3);
        else if (r < 85)
            d = $urandom_range(4, 70);
        else
            d = -int'($urandom_range(0, 3));
        if (d < 0 && sb.grid_idx < 64'(-d))
            tgt = '0;
        else
            tgt = (d < 0) ? sb.grid_idx - 64'(-d) : sb.grid_idx + 64'(d);
        if (tgt == '0)
            return (sb.epoch == '0) ? '0 : sb.epoch - 1'b1;
        return grid_time(tgt - 64'd1, rnd64() % sb.interval());
    endfunction

    task automatic write_cfg(input logic [IVL_W-1:0] ivl, input logic [NOW_W-1:0] epoch,
                             input logic mode, input logic [LIM_W-1:0] limit);
        logic [CFG_DATA_W-1:0] val[4];
        logic [CFG_IDX_W-1:0]  idx[4];
        idx = '{REG_TICK_INTERVAL, REG_EPOCH_TIME, REG_LAG_MODE, REG_CATCH_UP_LIMIT};
        val = '{CFG_DATA_W'(ivl), epoch, CFG_DATA_W'(mode), CFG_DATA_W'(limit)};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            sb.set_reg(idx[i], val[i]);
        end
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic send_wakeup(input logic [NOW_W-1:0] now, input logic cancel);
        if (idle_on && $urandom_range(0, 2) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DATA_W'(now);
        s_tuser  <= cancel;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_wakeup(now, cancel);
    endtask

    // hold off until every owed tick has come back, then let the front end settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.owed_ticks.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic random_phase(input int items, input logic calm);
        logic [IVL_W-1:0] ivl;
        logic [NOW_W-1:0] epoch;
        logic [LIM_W-1:0] limit;
        logic [127:0]     reach;
        logic [127:0]     room;
        case ($urandom_range(0, 5))
            0:       ivl = '0;
            1:       ivl = IVL_W'($urandom_range(1, 16));
            2:       ivl = IVL_W'($urandom_range(17, 5000));
            3:       ivl = IVL_W'(rnd64());
            4:       ivl = IVL_DAY;
            default: ivl = IVL_MAX;
        endcase
        // keep the grid reachable well below the top of the time range
        reach = 128'(sb.grid_idx) + 128'd200;
        if (reach * 128'((ivl == '0) ? 1 : ivl) > 128'(TIME_MAX >> 1))
            ivl = IVL_W'(128'(TIME_MAX >> 1) / reach);
        room = 128'(TIME_MAX) - reach * 128'((ivl == '0) ? 1 : ivl);
        case ($urandom_range(0, 3))
            0:       epoch = '0;
            1:       epoch = NOW_W'(room);
            default: epoch = NOW_W'(128'(rnd64()) % (room + 128'd1));
        endcase
        case ($urandom_range(0, 4))
            0:       limit = '0;
            1:       limit = LIM_W'(1);
            2:       limit = LIM_W'($urandom_range(2, 63));
            3:       limit = LIM_W'(CATCH_UP_MAX);
            default: limit = LIM_W'($urandom_range(65, 127));
        endcase
        write_cfg(ivl, epoch, 1'($urandom_range(0, 1)), limit);
        idle_on = calm ? 1'b0 : ($urandom_range(0, 3) != 0);
        for (int i = 0; i < items; i++)
            send_wakeup(pick_now(), $urandom_range(0, 7) == 0);
        drain();
    endtask

    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_tick(m_tdata, m_tlast);
    end

    initial
    begin
        #4_000_000;
        $display("tb: done, errors");
        $finish;
    end

    initial
    begin
        sb         = new();
        idle_on    = 1'b1;
        n_settings = 0;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, skip mode: first tick, repeat, skipped run, cancel
        send_wakeup(NOW_W'(0), 1'b0);
        send_wakeup(NOW_W'(0), 1'b0);
        send_wakeup(NOW_W'(5_500_000), 1'b0);
        send_wakeup(NOW_W'(7_000_000), 1'b1);
        send_wakeup(NOW_W'(7_999_999), 1'b0);
        send_wakeup(NOW_W'(8_000_000), 1'b0);
        drain();

        // zero interval acts as one, zero limit acts as one, early wake-up
        write_cfg('0, NOW_W'(1000), 1'b1, '0);
        send_wakeup(NOW_W'(999), 1'b0);
        send_wakeup(NOW_W'(1020), 1'b0);
        send_wakeup(NOW_W'(1021), 1'b1);
        send_wakeup(NOW_W'(1021), 1'b0);
        drain();

        // widest interval, limit above the cap, all-ones wake-up time
        write_cfg(IVL_MAX, '0, 1'b1, '1);
        send_wakeup(TIME_MAX, 1'b1);
        send_wakeup(TIME_MAX, 1'b0);
        drain();

        // one-day interval with an odd epoch
        write_cfg(IVL_DAY, NOW_W'(12345), 1'b1, LIM_W'(CATCH_UP_MAX));
        send_wakeup(grid_time(64'd65536, 64'd7), 1'b0);
        send_wakeup(grid_time(64'd65539, 64'd0), 1'b0);
        drain();

        for (int p = 0; p < 6; p++)
            random_phase(48, p == 5);

        // run the grid index to the top so the tick number wraps
        write_cfg(IVL_W'(1), '0, 1'b1, LIM_W'(CATCH_UP_MAX));
        send_wakeup(TIME_MAX, 1'b0);
        send_wakeup(TIME_MAX, 1'b0);
        drain();

        if (sb.owed_ticks.size() != 0)
        begin
            sb.errors++;
            $display("%0t: %0d expected ticks never arrived", $time, sb.owed_ticks.size());
        end
        $display("tb: %0d wake-ups sent, %0d ticks checked over %0d register settings",
                 sb.n_wakeups, sb.n_checked, n_settings + 1);
        $display("tb: skip and catch-up modes, cancel, early wake-ups, limit clamping, index wrap");
        if (sb.errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

/* files.f */
sv/frtcu_pkg.sv
sv/frtcu_front.sv
sv/frtcu_queue.sv
sv/frtcu_back.sv
sv/fixed_rate_tick_catch_up.sv
verif/tb.sv
